/* sv/rcpwm_pkg.sv */
// ---------------------------------------------------------------------------
// rcpwm_pkg
// Shared constants, item codes and lane status types of the RC pulse
// capture block.
// ---------------------------------------------------------------------------
`default_nettype none

package rcpwm_pkg;

  localparam int NUM_CHANNELS_DEF  = 4;
  localparam int AVG_COUNT_DEF     = 16;
  localparam int SCALE_DIVISOR_DEF = 4;

  localparam int WIDTH_W = 16;
  localparam int EDGE_W  = 4;
  localparam int CHAN_W  = 2;
  localparam int FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EDGE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  typedef logic [WIDTH_W-1:0] usec_t;

  typedef struct packed {
    logic rise;
    logic fall;
  } lane_cmd_t;

  typedef struct packed {
    usec_t last_width;
    usec_t offset_lo;
    logic  calibrated;
  } lane_stat_t;

endpackage

`default_nettype wire

/* sv/rcpwm_if.sv */
// ---------------------------------------------------------------------------
// rcpwm_if
// Valid/ready channels of the RC pulse capture block: request words in,
// width words out.
// ---------------------------------------------------------------------------
`default_nettype none

interface rcpwm_in_if import rcpwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [EDGE_W-1:0]   edge_mask;
  logic [EDGE_W-1:0]   pin_levels;
  logic [CHAN_W-1:0]   channel;
  logic                raw_select;

  modport source (output valid, func, edge_mask, pin_levels, channel, raw_select,
                  input ready);
  modport sink   (input valid, func, edge_mask, pin_levels, channel, raw_select,
                  output ready);
endinterface

interface rcpwm_out_if import rcpwm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [WIDTH_W-1:0] width_value;
  logic                      all_calibrated;

  modport source (output valid, width_value, all_calibrated, input ready);
  modport sink   (input valid, width_value, all_calibrated, output ready);
endinterface

`default_nettype wire

/* sv/rcpwm_lane.sv */
// ---------------------------------------------------------------------------
// rcpwm_lane
// One channel: start time capture, width measurement, averaging of the
// first pulses and center offset calibration.
// ---------------------------------------------------------------------------
`default_nettype none

module rcpwm_lane import rcpwm_pkg::*; #(
  parameter int AVG_COUNT = AVG_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lane_cmd_t  cmd,
  input  wire usec_t      now,
  output lane_stat_t      stat
);

  localparam int AVG_L  = $clog2(AVG_COUNT);
  localparam int ACC_W  = WIDTH_W + AVG_L;
  localparam int CNT_W  = $clog2(AVG_COUNT + 1);
  localparam int AVG_SH = ACC_W + AVG_L;
  localparam longint unsigned AVG_M =
    ((64'd1 << AVG_SH) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
  localparam int MUL_W  = ACC_W + 2;
  localparam int PROD_W = ACC_W + MUL_W;
  localparam logic [MUL_W-1:0] AVG_MC  = MUL_W'(AVG_M);
  localparam logic [CNT_W-1:0] AVG_CNT = CNT_W'(AVG_COUNT);

  usec_t              start_r;
  usec_t              last_r;
  logic [ACC_W-1:0]   acc_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               cal_r;

  usec_t              width_nxt;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   mean;

  assign width_nxt = now - start_r;

  // divide the sum by the pulse count: reciprocal multiply, exact for ACC_W bits
  assign prod = PROD_W'(acc_r) * PROD_W'(AVG_MC);
  assign mean = ACC_W'(prod >> AVG_SH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      last_r  <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      cal_r   <= 1'b0;
    end else begin
      if (cmd.rise) begin
        start_r <= now;
      end
      if (cmd.fall) begin
        last_r <= width_nxt;
        if (cnt_r < AVG_CNT) begin
          acc_r <= acc_r + ACC_W'(width_nxt);
          cnt_r <= cnt_r + CNT_W'(1);
        end else if (!cal_r) begin
          cal_r <= 1'b1;
          acc_r <= mean;
        end
      end
    end
  end

  assign stat.last_width = last_r;
  assign stat.offset_lo  = acc_r[WIDTH_W-1:0];
  assign stat.calibrated = cal_r;

endmodule

`default_nettype wire

/* sv/rcpwm_merge.sv */
// ---------------------------------------------------------------------------
// rcpwm_merge
// Read path: picks the requested lane, passes its raw width or centers and
// scales it, and holds the result word until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module rcpwm_merge import rcpwm_pkg::*; #(
  parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
  parameter int SCALE_DIVISOR = SCALE_DIVISOR_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_take,
  input  wire logic [CHAN_W-1:0] channel,
  input  wire logic              raw_select,
  input  wire lane_stat_t        lane_stat [NUM_CHANNELS],
  input  wire logic              all_cal,
  output logic                   rd_ready,
  rcpwm_out_if.source            out_chan
);

  localparam int SCALE_L  = $clog2(SCALE_DIVISOR);
  localparam int SCALE_SH = WIDTH_W + SCALE_L;
  localparam longint unsigned SCALE_M =
    ((64'd1 << SCALE_SH) + 64'(SCALE_DIVISOR) - 64'd1) / 64'(SCALE_DIVISOR);
  localparam int MUL_W  = WIDTH_W + 2;
  localparam int PROD_W = WIDTH_W + MUL_W;
  localparam logic [MUL_W-1:0] SCALE_MC = MUL_W'(SCALE_M);

  // stage 1: lane select and centering
  logic               s1_valid_r;
  logic               s1_raw_r, s1_present_r, s1_allcal_r;
  usec_t              s1_width_r, s1_diff_r;
  // stage 2: magnitude times reciprocal
  logic               s2_valid_r;
  logic               s2_raw_r, s2_present_r, s2_allcal_r, s2_neg_r;
  usec_t              s2_width_r;
  logic [PROD_W-1:0]  s2_prod_r;
  // output word
  logic               out_valid_r;
  logic signed [WIDTH_W-1:0] out_value_r;
  logic               out_allcal_r;

  logic               out_mv, s2_mv, s1_mv;
  lane_stat_t         sel;
  logic               present;
  usec_t              mag;
  logic [PROD_W-1:0]  prod_nxt;
  usec_t              quot;
  logic signed [WIDTH_W-1:0] value_nxt;

  assign out_mv   = !out_valid_r || out_chan.ready;
  assign s2_mv    = !s2_valid_r || out_mv;
  assign s1_mv    = !s1_valid_r || s2_mv;
  assign rd_ready = s1_mv;

  always_comb begin
    sel = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (32'(channel) == 32'(k)) begin
        sel = lane_stat[k];
      end
    end
  end

  assign present = 32'(channel) < 32'(NUM_CHANNELS);

  assign mag      = s1_diff_r[WIDTH_W-1] ? (~s1_diff_r + usec_t'(1)) : s1_diff_r;
  assign prod_nxt = PROD_W'(mag) * PROD_W'(SCALE_MC);

  // truncate toward zero: scale the magnitude, then restore the sign
  assign quot = WIDTH_W'(s2_prod_r >> SCALE_SH);

  always_comb begin
    if (!s2_present_r) begin
      value_nxt = '0;
    end else if (s2_raw_r) begin
      value_nxt = s2_width_r;
    end else if (s2_neg_r) begin
      value_nxt = -quot;
    end else begin
      value_nxt = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_mv) begin
        s1_valid_r <= rd_take;
      end
      if (s2_mv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_mv) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_mv) begin
      s1_raw_r     <= raw_select;
      s1_present_r <= present;
      s1_allcal_r  <= all_cal;
      s1_width_r   <= sel.last_width;
      s1_diff_r    <= sel.last_width - sel.offset_lo;
    end
    if (s2_mv) begin
      s2_raw_r     <= s1_raw_r;
      s2_present_r <= s1_present_r;
      s2_allcal_r  <= s1_allcal_r;
      s2_width_r   <= s1_width_r;
      s2_neg_r     <= s1_diff_r[WIDTH_W-1];
      s2_prod_r    <= prod_nxt;
    end
    if (out_mv) begin
      out_value_r  <= value_nxt;
      out_allcal_r <= s2_allcal_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.width_value    = out_value_r;
  assign out_chan.all_calibrated = out_allcal_r;

endmodule

`default_nettype wire

/* sv/rc_pwm_capture_with_center_cal.sv */
// ---------------------------------------------------------------------------
// rc_pwm_capture_with_center_cal
// Multi-channel RC pulse width capture with center offset calibration.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan carries one request word per handshake: a microsecond tick, a
//   pin edge word (changed-pin mask plus levels), or a width read.
//   Ticks and edges update state at the accepting edge and give no word on
//   out_chan. A read gives one word: raw or centered/scaled width and the
//   all-calibrated flag, sampled at the moment the read is accepted.
//   Throughput is one request word per cycle while in_chan.ready is high. A
//   read word passes the select/center, scale multiply and output
//   registers on its way to out_chan.
//   Each channel has its own capture lane; calibration divides by the pulse
//   count through a reciprocal multiply in the lane.
//   Reset (rst_n low, synchronous) clears the counter, all lane state and
//   the read pipeline; no clearing pass follows.
//   When the receiver stalls, the output word holds; the read pipeline
//   keeps filling, and in_chan.ready drops only once three read words wait.
// ---------------------------------------------------------------------------
`default_nettype none

module rc_pwm_capture_with_center_cal import rcpwm_pkg::*; #(
  parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
  parameter int AVG_COUNT     = AVG_COUNT_DEF,
  parameter int SCALE_DIVISOR = SCALE_DIVISOR_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  rcpwm_in_if.sink     in_chan,
  rcpwm_out_if.source  out_chan
);

  logic                    in_take, tick_take, edge_take, rd_take, rd_ready;
  usec_t                   usec_r, usec_nxt;
  lane_cmd_t               cmd  [NUM_CHANNELS];
  lane_stat_t              stat [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] cal_vec;
  logic                    all_cal;

  assign in_chan.ready = rd_ready;
  assign in_take   = in_chan.valid && rd_ready;
  assign tick_take = in_take && (in_chan.func == FUNC_TICK);
  assign edge_take = in_take && (in_chan.func == FUNC_EDGE);
  assign rd_take   = in_take && (in_chan.func == FUNC_READ);

  assign usec_nxt = tick_take ? usec_r + usec_t'(1) : usec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usec_r <= '0;
    end else begin
      usec_r <= usec_nxt;
    end
  end

  for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_lane
    if (k < EDGE_W) begin : g_pin
      assign cmd[k].rise = edge_take && in_chan.edge_mask[k] && in_chan.pin_levels[k];
      assign cmd[k].fall = edge_take && in_chan.edge_mask[k] && !in_chan.pin_levels[k];
    end else begin : g_nopin
      // no pin bit reaches this lane
      assign cmd[k] = '0;
    end

    rcpwm_lane #(
      .AVG_COUNT (AVG_COUNT)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[k]),
      .now   (usec_r),
      .stat  (stat[k])
    );

    assign cal_vec[k] = stat[k].calibrated;
  end

  assign all_cal = &cal_vec;

  rcpwm_merge #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .SCALE_DIVISOR (SCALE_DIVISOR)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_take    (rd_take),
    .channel    (in_chan.channel),
    .raw_select (in_chan.raw_select),
    .lane_stat  (stat),
    .all_cal    (all_cal),
    .rd_ready   (rd_ready),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

/* sv/rcpwm_chk.sv */
// ---------------------------------------------------------------------------
// rcpwm_chk
// Port-level checks of the RC pulse capture block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module rcpwm_chk import rcpwm_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [FUNC_W-1:0] in_func,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_all_calibrated
);

  logic [2:0] pend_r, pend_nxt;
  logic       seen_cal_r;
  logic       rd_take, out_take;

  assign rd_take  = in_valid && in_ready && (in_func == FUNC_READ);
  assign out_take = out_valid && out_ready;

  // track read words in flight
  assign pend_nxt = pend_r + 3'(rd_take) - 3'(out_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      seen_cal_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (out_valid && out_all_calibrated) begin
        seen_cal_r <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("out word without a read");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more than three read words in flight");

  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_cal_r |-> out_all_calibrated)
    else $error("all_calibrated fell after being reported");

endmodule

bind rc_pwm_capture_with_center_cal rcpwm_chk u_rcpwm_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .in_func            (in_chan.func),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_all_calibrated (out_chan.all_calibrated)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RC pulse width capture block: a queue-fed
// request driver, a width word monitor and a request-level capture predictor.
// Directed words cover reads out of reset, unused codes and zero widths,
// then framed rise/tick/fall traffic with reads runs the lanes through
// center calibration while both channels idle at random.
// ---------------------------------------------------------------------------

module tb_top;
  import rcpwm_pkg::*;

  localparam int NUM_CH    = NUM_CHANNELS_DEF;
  localparam int AVG_N     = AVG_COUNT_DEF;
  localparam int SCALE_DIV = SCALE_DIVISOR_DEF;
  localparam int ACC_W     = WIDTH_W + $clog2(AVG_N);
  localparam int TALLY_W   = $clog2(AVG_N + 1);

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [EDGE_W-1:0] edge_mask;
    logic [EDGE_W-1:0] pin_levels;
    logic [CHAN_W-1:0] channel;
    logic              raw_select;
    int unsigned       gap;
  } pin_req_t;

  typedef struct {
    logic signed [WIDTH_W-1:0] width_value;
    logic                      all_calibrated;
  } width_word_t;

  logic clk;
  logic rst_n;

  rcpwm_in_if  in_bus ();
  rcpwm_out_if out_bus ();

  rc_pwm_capture_with_center_cal u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Stimulus and expectation stores
  pin_req_t    req_queue[$];
  width_word_t width_expect[$];

  // Predictor state
  usec_t              usec_now;
  usec_t              rise_stamp   [NUM_CH];
  usec_t              held_width   [NUM_CH];
  logic [ACC_W-1:0]   center_acc   [NUM_CH];
  logic [TALLY_W-1:0] pulse_tally  [NUM_CH];
  logic [NUM_CH-1:0]  lane_done;

  int errors;
  int words_checked;
  int falls_seen;
  int cycle_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic int unsigned draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic queue_req(input logic [FUNC_W-1:0] f, input logic [EDGE_W-1:0] m,
                           input logic [EDGE_W-1:0] l, input logic [CHAN_W-1:0] c,
                           input logic r, input int unsigned g);
    pin_req_t req;
    req.func       = f;
    req.edge_mask  = m;
    req.pin_levels = l;
    req.channel    = c;
    req.raw_select = r;
    req.gap        = g;
    req_queue.push_back(req);
  endtask

  task automatic capture_model_step(input pin_req_t req);
    width_word_t          word;
    usec_t                w;
    logic [WIDTH_W-1:0]   diff;
    int                   centered;
    int                   k;
    if (req.func == FUNC_TICK) begin
      usec_now = usec_now + usec_t'(1);
    end else if (req.func == FUNC_EDGE) begin
      for (k = 0; k < NUM_CH && k < EDGE_W; k++) begin
        if (req.edge_mask[k]) begin
          if (req.pin_levels[k]) begin
            rise_stamp[k] = usec_now;
          end else begin
            w = usec_now - rise_stamp[k];
            held_width[k] = w;
            falls_seen++;
            if (pulse_tally[k] < TALLY_W'(AVG_N)) begin
              center_acc[k]  = center_acc[k] + ACC_W'(w);
              pulse_tally[k] = pulse_tally[k] + TALLY_W'(1);
            end else if (!lane_done[k]) begin
              lane_done[k]  = 1'b1;
              center_acc[k] = center_acc[k] / ACC_W'(AVG_N);
            end
          end
        end
      end
    end else if (req.func == FUNC_READ) begin
      word.width_value = '0;
      if (32'(req.channel) < NUM_CH) begin
        if (req.raw_select) begin
          word.width_value = held_width[req.channel];
        end else begin
          // wrap the difference to 16 bits, then divide toward zero
          diff = held_width[req.channel] - center_acc[req.channel][WIDTH_W-1:0];
          centered = $signed(diff);
          centered = centered / SCALE_DIV;
          word.width_value = centered[WIDTH_W-1:0];
        end
      end
      word.all_calibrated = &lane_done;
      width_expect.push_back(word);
    end
  endtask

  // Input side: accept and predict at the rising edge
  bit       in_taken;
  pin_req_t next_req;
  bit       have_next;
  int       gap_left;

  always @(posedge clk) begin
    pin_req_t seen;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      seen.func       = in_bus.func;
      seen.edge_mask  = in_bus.edge_mask;
      seen.pin_levels = in_bus.pin_levels;
      seen.channel    = in_bus.channel;
      seen.raw_select = in_bus.raw_select;
      seen.gap        = 0;
      capture_model_step(seen);
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Driver: change inputs at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (!have_next && req_queue.size() > 0) begin
        next_req  = req_queue.pop_front();
        gap_left  = next_req.gap;
        have_next = 1'b1;
      end
      if (have_next && gap_left == 0) begin
        in_bus.func       <= next_req.func;
        in_bus.edge_mask  <= next_req.edge_mask;
        in_bus.pin_levels <= next_req.pin_levels;
        in_bus.channel    <= next_req.channel;
        in_bus.raw_select <= next_req.raw_select;
        in_bus.valid      <= 1'b1;
        have_next = 1'b0;
      end else begin
        in_bus.valid <= 1'b0;
        if (have_next) gap_left--;
      end
    end
  end

  // Monitor: check each width word against the oldest expectation
  bit out_taken;
  bit sink_calm;
  int stall_left;

  always @(posedge clk) begin
    width_word_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      out_taken <= 1'b1;
      if (width_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected word width=%0d cal=%0b",
                                  out_bus.width_value, out_bus.all_calibrated));
      end else begin
        want = width_expect.pop_front();
        words_checked++;
        if (out_bus.width_value !== want.width_value)
          report_mismatch($sformatf("width_value got %0d want %0d",
                                    out_bus.width_value, want.width_value));
        if (out_bus.all_calibrated !== want.all_calibrated)
          report_mismatch($sformatf("all_calibrated got %0b want %0b",
                                    out_bus.all_calibrated, want.all_calibrated));
      end
    end else begin
      out_taken <= 1'b0;
    end
  end

  // Sink ready: stall at random before each word, not at all while calm
  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 15) == 0) sink_calm = ~sink_calm;
      stall_left = sink_calm ? 0 : $urandom_range(0, 10);
    end
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int          k;
    int          n;
    int          base;
    int          next_mode_at;
    int          kind;
    bit          calm;
    logic [3:0]  m;
    logic [3:0]  fm;

    rst_n = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.func       = FUNC_TICK;
    in_bus.edge_mask  = '0;
    in_bus.pin_levels = '0;
    in_bus.channel    = '0;
    in_bus.raw_select = 1'b0;
    out_bus.ready     = 1'b0;
    errors = 0;
    words_checked = 0;
    falls_seen = 0;
    cycle_count = 0;
    have_next = 1'b0;
    gap_left = 0;
    sink_calm = 1'b0;
    stall_left = $urandom_range(0, 10);
    usec_now = '0;
    lane_done = '0;
    for (k = 0; k < NUM_CH; k++) begin
      rise_stamp[k]  = '0;
      held_width[k]  = '0;
      center_acc[k]  = '0;
      pulse_tally[k] = '0;
    end

    // Directed: reads out of reset, unused code, zero width, mixed masks
    queue_req(FUNC_READ,   4'h0, 4'h0, 2'd0, 1'b1, draw_gap(0));
    queue_req(FUNC_READ,   4'h0, 4'h0, 2'd3, 1'b0, draw_gap(0));
    queue_req(FUNC_UNUSED, 4'hF, 4'hF, 2'd3, 1'b1, draw_gap(0));
    queue_req(FUNC_READ,   4'h0, 4'h0, 2'd1, 1'b1, draw_gap(0));
    queue_req(FUNC_EDGE,   4'hF, 4'hF, 2'd0, 1'b0, draw_gap(0));
    queue_req(FUNC_EDGE,   4'hF, 4'h0, 2'd0, 1'b0, draw_gap(0));
    queue_req(FUNC_READ,   4'h0, 4'h0, 2'd2, 1'b1, draw_gap(0));
    queue_req(FUNC_TICK,   4'hF, 4'hF, 2'd3, 1'b1, draw_gap(0));
    queue_req(FUNC_TICK,   4'h0, 4'h0, 2'd0, 1'b0, draw_gap(0));
    queue_req(FUNC_EDGE,   4'h5, 4'hF, 2'd0, 1'b0, draw_gap(0));
    queue_req(FUNC_TICK,   4'h0, 4'h0, 2'd0, 1'b0, draw_gap(0));
    queue_req(FUNC_EDGE,   4'hF, 4'hA, 2'd0, 1'b0, draw_gap(0));
    queue_req(FUNC_TICK,   4'h0, 4'h0, 2'd0, 1'b0, draw_gap(0));
    queue_req(FUNC_EDGE,   4'hA, 4'h0, 2'd0, 1'b0, draw_gap(0));
    for (k = 0; k < 4; k++) begin
      queue_req(FUNC_READ, 4'h0, 4'h0, k[1:0], 1'b1, draw_gap(0));
      queue_req(FUNC_READ, 4'h0, 4'h0, k[1:0], 1'b0, draw_gap(0));
    end

    // Random: mostly rise/tick/fall frames with reads, some noise
    base = req_queue.size();
    next_mode_at = 0;
    calm = 1'b0;
    while (req_queue.size() < base + RANDOM_ITEMS) begin
      if (req_queue.size() - base >= next_mode_at) begin
        calm = ($urandom_range(0, 3) == 0);
        next_mode_at += 50;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        m = 4'($urandom_range(1, 15));
        queue_req(FUNC_EDGE, m, m | 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), draw_gap(calm));
        n = $urandom_range(0, 15);
        for (k = 0; k < n; k++) begin
          queue_req(FUNC_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), draw_gap(calm));
          if ($urandom_range(0, 7) == 0)
            queue_req(FUNC_READ, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), draw_gap(calm));
        end
        // usually close the same lanes, sometimes a stray subset
        fm = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : m;
        queue_req(FUNC_EDGE, fm, 4'($urandom_range(0, 15)) & ~fm, 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), draw_gap(calm));
        n = $urandom_range(1, 2);
        for (k = 0; k < n; k++)
          queue_req(FUNC_READ, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), draw_gap(calm));
      end else if (kind == 7) begin
        queue_req(FUNC_READ, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), draw_gap(calm));
      end else begin
        queue_req(FUNC_W'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), draw_gap(calm));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (req_queue.size() == 0 && !have_next);
    @(posedge clk);
    wait (!in_bus.valid);
    wait (width_expect.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d width words over %0d falling edges; lanes calibrated %b",
             words_checked, falls_seen, lane_done);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
sv/rcpwm_pkg.sv
sv/rcpwm_if.sv
sv/rcpwm_lane.sv
sv/rcpwm_merge.sv
sv/rc_pwm_capture_with_center_cal.sv
sv/rcpwm_chk.sv
tb/sv/tb_top.sv
